@@ hw/rtl/tcc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the triangle cull, clip
// and project block. No dependencies; every RTL module imports this package.

package tcc_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned CfgW       = 31;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgW-1:0] NearPlaneReset = 31'd19661;     // 0.3 in Q16.16
  localparam logic [CfgW-1:0] ScreenDistReset = 31'd16777216; // 256.0 in Q16.16

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEAR_PLANE  = 1'b0,
    CFG_SCREEN_DIST = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } tcc_tri_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic signed [CoordW-1:0] depth;
    logic                     was_clipped;
    logic                     last_vertex;
  } tcc_vtx_t;

  // Queue entry: the triangle plus, per vertex, whether it lies on or in
  // front of the near plane.
  typedef struct packed {
    tcc_tri_t   geom;
    logic [2:0] keep;
  } tcc_job_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } tcc_pt_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SLOT,
    B_SDIV,
    B_CX,
    B_CY,
    B_CZ,
    B_PMX,
    B_PMY,
    B_PMW,
    B_PDIV,
    B_OUT
  } back_state_e;

  function automatic tcc_pt_t vsel(input tcc_tri_t g, input logic [1:0] idx);
    tcc_pt_t p;
    case (idx)
      2'd0:    p = '{x: g.v0_x, y: g.v0_y, z: g.v0_z};
      2'd1:    p = '{x: g.v1_x, y: g.v1_y, z: g.v1_z};
      default: p = '{x: g.v2_x, y: g.v2_y, z: g.v2_z};
    endcase
    return p;
  endfunction

  // Clamp a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [33:0] v);
    logic signed [CoordW-1:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) r = 32'sh7FFFFFFF;
    else if (v[33] && (v[32:31] != 2'b11)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // c1 plus or minus round(prod / 2^30), half away from zero on the magnitude.
  function automatic logic signed [CoordW-1:0] cross_coord(
    input logic signed [CoordW-1:0] c1,
    input logic                     neg,
    input logic [63:0]              prod
  );
    logic [63:0]        rnd;
    logic signed [33:0] off;
    logic signed [33:0] base;
    logic signed [33:0] r;
    rnd  = prod + (64'd1 << 29);
    off  = $signed({1'b0, rnd[62:30]});
    base = {{2{c1[31]}}, c1};
    r    = neg ? (base - off) : (base + off);
    return sat32(r);
  endfunction

  // Finish c*D/z from the magnitude quotient: sign, saturate, zero depth.
  function automatic logic signed [CoordW-1:0] proj_fin(
    input logic signed [CoordW-1:0] c,
    input logic [CoordW-1:0]        q,
    input logic                     ovf,
    input logic                     zero_z
  );
    logic signed [CoordW-1:0] r;
    if (zero_z || ovf) begin
      if (c[31]) r = 32'sh80000000;
      else if (c != '0) r = 32'sh7FFFFFFF;
      else r = '0;
    end else if (c[31]) begin
      r = (q > 32'h80000000) ? 32'sh80000000 : $signed(-q);
    end else begin
      r = q[31] ? 32'sh7FFFFFFF : $signed(q);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tcc_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from tcc_pkg at instantiation.

interface tcc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/tcc_fifo.sv @@
// Short register queue between the classifying front and the clipping back.
// Depends on tcc_pkg and tcc_stream_if.

module tcc_fifo
  import tcc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth,
  parameter type         T     = tcc_job_t
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcc_stream_if.sink   push,
  tcc_stream_if.source pop
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T               mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign push.ready = (cnt_q != CntW'(Depth));
  assign pop.valid  = (cnt_q != '0);
  assign pop.data   = mem_q[rd_q];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push.data;
  end

endmodule

@@ hw/rtl/tcc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tcc_pkg only by convention; no shared types used beyond widths.

module tcc_div
  import tcc_pkg::*;
#(
  parameter int unsigned VW = CoordW,
  parameter int unsigned QW = CoordW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [VW-1:0] den_i,
  output logic          busy_o,
  output logic          ovf_o,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned CntW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [VW-1:0]   rem_q, den_q;
  logic [QW-1:0]   lo_q;
  logic            ovf_q;
  logic [VW:0]     trial;
  logic            ge;

  assign trial  = {rem_q, lo_q[QW-1]};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(QW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
      ovf_q <= (num_hi_i >= den_i);
    end else if (busy_q) begin
      rem_q <= ge ? VW'(trial - {1'b0, den_q}) : trial[VW-1:0];
      lo_q  <= {lo_q[QW-2:0], ge};
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

@@ hw/rtl/tcc_front.sv @@
// Front end: accepts triangles, forms the exact triple product for the
// facing test and the near-plane masks, and queues survivors. Needs tcc_pkg.

module tcc_front
  import tcc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] near_plane_i,
  tcc_stream_if.sink      tri_in,
  tcc_stream_if.source    job_out
);

  front_state_e state_q, state_d;
  tcc_tri_t     geom_q;
  logic [2:0]   term_q;
  logic [1:0]   phase_q;
  logic signed [65:0] mul_q;
  logic signed [31:0] ph_q;
  logic signed [97:0] acc_q;

  logic signed [31:0] op_a, op_b, op_c;
  logic               c_neg;
  logic signed [32:0] cs, ma, mb;
  logic [2:0]         keep, ahead;
  logic               cull, take;
  logic signed [32:0] ncp;

  // term k of the triple product: a*b*c with sign
  always_comb begin
    op_a  = geom_q.v0_x;
    op_b  = geom_q.v1_y;
    op_c  = geom_q.v2_z;
    c_neg = 1'b0;
    unique case (term_q)
      3'd0: begin op_a = geom_q.v0_x; op_b = geom_q.v1_y; op_c = geom_q.v2_z; end
      3'd1: begin op_a = geom_q.v0_x; op_b = geom_q.v1_z; op_c = geom_q.v2_y; c_neg = 1'b1; end
      3'd2: begin op_a = geom_q.v0_y; op_b = geom_q.v1_z; op_c = geom_q.v2_x; end
      3'd3: begin op_a = geom_q.v0_y; op_b = geom_q.v1_x; op_c = geom_q.v2_z; c_neg = 1'b1; end
      3'd4: begin op_a = geom_q.v0_z; op_b = geom_q.v1_x; op_c = geom_q.v2_y; end
      default: begin op_a = geom_q.v0_z; op_b = geom_q.v1_y; op_c = geom_q.v2_x; c_neg = 1'b1; end
    endcase
  end

  assign cs = c_neg ? -{op_c[31], op_c} : {op_c[31], op_c};

  always_comb begin
    ma = {op_a[31], op_a};
    mb = {op_b[31], op_b};
    case (phase_q)
      2'd1: begin ma = $signed({1'b0, mul_q[31:0]}); mb = cs; end
      2'd2: begin ma = {ph_q[31], ph_q}; mb = cs; end
      default: ;
    endcase
  end

  assign ncp      = $signed({2'b00, near_plane_i});
  assign keep[0]  = ($signed({geom_q.v0_z[31], geom_q.v0_z}) >= ncp);
  assign keep[1]  = ($signed({geom_q.v1_z[31], geom_q.v1_z}) >= ncp);
  assign keep[2]  = ($signed({geom_q.v2_z[31], geom_q.v2_z}) >= ncp);
  assign ahead[0] = ($signed({geom_q.v0_z[31], geom_q.v0_z}) > ncp);
  assign ahead[1] = ($signed({geom_q.v1_z[31], geom_q.v1_z}) > ncp);
  assign ahead[2] = ($signed({geom_q.v2_z[31], geom_q.v2_z}) > ncp);
  assign cull     = (!acc_q[97] && (acc_q != '0)) || (ahead == 3'b000);

  assign job_out.data.geom = geom_q;
  assign job_out.data.keep = keep;
  assign take = tri_in.valid && tri_in.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (take) state_d = F_RUN;
      F_RUN:  if (term_q == 3'd5 && phase_q == 2'd3) state_d = F_PUSH;
      F_PUSH: if (cull || job_out.ready) state_d = take ? F_RUN : F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    tri_in.ready  = 1'b0;
    job_out.valid = 1'b0;
    unique case (state_q)
      F_IDLE: tri_in.ready = 1'b1;
      F_PUSH: begin
        job_out.valid = !cull;
        tri_in.ready  = cull || job_out.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      term_q  <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        term_q  <= '0;
        phase_q <= '0;
      end else if (state_q == F_RUN) begin
        phase_q <= phase_q + 1'b1;
        if (phase_q == 2'd3) term_q <= term_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      geom_q <= tri_in.data;
      acc_q  <= '0;
    end else if (state_q == F_RUN) begin
      mul_q <= ma * mb;
      if (phase_q == 2'd1) ph_q <= mul_q[63:32];
      if (phase_q == 2'd2) acc_q <= acc_q + {{32{mul_q[65]}}, mul_q};
      if (phase_q == 2'd3) acc_q <= acc_q + $signed({mul_q, 32'b0});
    end
  end

endmodule

@@ hw/rtl/tcc_back.sv @@
// Back end: walks the polygon slots of a queued triangle, finds crossing
// points and projects each vertex. Needs tcc_pkg, tcc_stream_if, tcc_div.

module tcc_back
  import tcc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] near_plane_i,
  input  logic [CfgW-1:0] screen_dist_i,
  tcc_stream_if.sink      job_in,
  tcc_stream_if.source    vtx_out
);

  back_state_e state_q, state_d;
  tcc_job_t    job_q;
  logic [2:0]  slot_q;
  logic [63:0] mul_q;
  logic signed [31:0] cur_x_q, cur_y_q, cur_z_q;
  tcc_vtx_t    out_q;
  logic        out_valid_q;

  logic [1:0]  vi, nx;
  logic        is_cross, slot_ok, last;
  logic [5:0]  smask;
  tcc_pt_t     p1, p2;
  logic signed [32:0] dx, dy, dz, nd;
  logic [31:0] adx, ady, adz, and_m, ax, ay;
  logic [31:0] m_a, m_b;
  logic        out_free, pop;
  logic        s_start, x_start, y_start;
  logic        s_busy, x_busy, y_busy, s_ovf, x_ovf, y_ovf;
  logic [30:0] s_quo;
  logic [31:0] x_quo, y_quo;

  // slot 2i is vertex i, slot 2i+1 the crossing from vertex i to the next
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smask[2*i]   = job_q.keep[i];
      smask[2*i+1] = job_q.keep[i] != job_q.keep[(i + 1) % 3];
    end
  end

  assign vi       = slot_q[2:1];
  assign is_cross = slot_q[0];
  assign nx       = (vi == 2'd2) ? 2'd0 : vi + 2'd1;
  assign slot_ok  = smask[slot_q];

  always_comb begin
    last = 1'b1;
    for (int j = 0; j < 6; j++) begin
      if (j > int'(slot_q) && smask[j]) last = 1'b0;
    end
  end

  assign p1 = vsel(job_q.geom, vi);
  assign p2 = vsel(job_q.geom, nx);
  assign dx = {p2.x[31], p2.x} - {p1.x[31], p1.x};
  assign dy = {p2.y[31], p2.y} - {p1.y[31], p1.y};
  assign dz = {p2.z[31], p2.z} - {p1.z[31], p1.z};
  assign nd = $signed({2'b00, near_plane_i}) - {p1.z[31], p1.z};
  assign adx   = dx[32] ? 32'(-dx) : dx[31:0];
  assign ady   = dy[32] ? 32'(-dy) : dy[31:0];
  assign adz   = dz[32] ? 32'(-dz) : dz[31:0];
  assign and_m = nd[32] ? 32'(-nd) : nd[31:0];
  assign ax    = cur_x_q[31] ? 32'(-cur_x_q) : cur_x_q;
  assign ay    = cur_y_q[31] ? 32'(-cur_y_q) : cur_y_q;

  always_comb begin
    case (state_q)
      B_CX:    begin m_a = adx; m_b = {1'b0, s_quo}; end
      B_CY:    begin m_a = ady; m_b = {1'b0, s_quo}; end
      B_PMY:   begin m_a = ay;  m_b = {1'b0, screen_dist_i}; end
      default: begin m_a = ax;  m_b = {1'b0, screen_dist_i}; end
    endcase
  end

  assign out_free = !out_valid_q || vtx_out.ready;
  assign vtx_out.valid = out_valid_q;
  assign vtx_out.data  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (job_in.valid) state_d = B_SLOT;
      B_SLOT: if (slot_ok) state_d = is_cross ? B_SDIV : B_PMX;
      B_SDIV: if (!s_busy) state_d = B_CX;
      B_CX:   state_d = B_CY;
      B_CY:   state_d = B_CZ;
      B_CZ:   state_d = B_PMX;
      B_PMX:  state_d = B_PMY;
      B_PMY:  state_d = B_PMW;
      B_PMW:  state_d = B_PDIV;
      B_PDIV: if (!x_busy && !y_busy) state_d = B_OUT;
      B_OUT: begin
        if (out_free) begin
          if (!last) state_d = B_SLOT;
          else state_d = job_in.valid ? B_SLOT : B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_in.ready = 1'b0;
    s_start = 1'b0;
    x_start = 1'b0;
    y_start = 1'b0;
    unique case (state_q)
      B_IDLE: job_in.ready = 1'b1;
      B_SLOT: s_start = slot_ok && is_cross;
      B_PMY:  x_start = 1'b1;
      B_PMW:  y_start = 1'b1;
      B_OUT:  job_in.ready = out_free && last;
      default: ;
    endcase
  end

  assign pop = job_in.valid && job_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) slot_q <= '0;
      else if ((state_q == B_SLOT && !slot_ok) || (state_q == B_OUT && out_free))
        slot_q <= slot_q + 1'b1;
      if (state_q == B_OUT && out_free) out_valid_q <= 1'b1;
      else if (vtx_out.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) job_q <= job_in.data;
    mul_q <= m_a * m_b;
    if (state_q == B_SLOT && slot_ok && !is_cross) begin
      cur_x_q <= p1.x;
      cur_y_q <= p1.y;
      cur_z_q <= p1.z;
    end
    if (state_q == B_CY) cur_x_q <= cross_coord(p1.x, dx[32], mul_q);
    if (state_q == B_CZ) begin
      cur_y_q <= cross_coord(p1.y, dy[32], mul_q);
      cur_z_q <= $signed({1'b0, near_plane_i});
    end
    if (state_q == B_OUT && out_free) begin
      out_q.screen_x    <= proj_fin(cur_x_q, x_quo, x_ovf, cur_z_q == '0);
      out_q.screen_y    <= proj_fin(cur_y_q, y_quo, y_ovf, cur_z_q == '0);
      out_q.depth       <= cur_z_q;
      out_q.was_clipped <= ~&job_q.keep;
      out_q.last_vertex <= last;
    end
  end

  // crossing fraction: |near - z1| * 2^30 / |z2 - z1|
  tcc_div #(.VW(32), .QW(31)) u_sdiv (
    .clk_i, .rst_ni,
    .start_i  (s_start),
    .num_hi_i ({1'b0, and_m[31:1]}),
    .num_lo_i ({and_m[0], 30'b0}),
    .den_i    (adz),
    .busy_o   (s_busy),
    .ovf_o    (s_ovf),
    .quo_o    (s_quo)
  );

  tcc_div #(.VW(32), .QW(32)) u_xdiv (
    .clk_i, .rst_ni,
    .start_i  (x_start),
    .num_hi_i (mul_q[63:32]),
    .num_lo_i (mul_q[31:0]),
    .den_i    (cur_z_q),
    .busy_o   (x_busy),
    .ovf_o    (x_ovf),
    .quo_o    (x_quo)
  );

  tcc_div #(.VW(32), .QW(32)) u_ydiv (
    .clk_i, .rst_ni,
    .start_i  (y_start),
    .num_hi_i (mul_q[63:32]),
    .num_lo_i (mul_q[31:0]),
    .den_i    (cur_z_q),
    .busy_o   (y_busy),
    .ovf_o    (y_ovf),
    .quo_o    (y_quo)
  );

`ifndef SYNTH
  a_sdiv_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SDIV && s_busy) |=> state_q == B_SDIV)
    else $error("left fraction wait early");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CX) |-> (!s_ovf && s_quo <= 31'h40000000))
    else $error("crossing fraction above one");
  a_pop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == B_SLOT && slot_q == 3'd0))
    else $error("new triangle not started at first slot");
`endif

endmodule

@@ hw/rtl/triangle_cull_clip_project.sv @@
// Top level of the triangle cull, clip and project block: configuration
// registers, front end, job queue and back end. Needs tcc_pkg and tcc_stream_if.
//
//  channel   dir  payload     per handshake
//  tri_in    in   tcc_tri_t   one camera-space triangle, three Q16.16 vertices
//  vtx_out   out  tcc_vtx_t   one projected vertex, last_vertex on the final one
//  cfg_*     in   31-bit reg  write near_plane (index 0) or projection distance (1)
//
// The front works the triple product for each triangle on one 33x33
// multiplier, four passes per term, and overlaps the back through the queue.
// The back works each kept vertex through the bit-serial projection dividers,
// each crossing point first through the fraction divider, and skips empty slots.
// A finished vertex waits in the output register while the next is worked on.
// Reset clears the control state and loads the default registers.

module triangle_cull_clip_project
  import tcc_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  tcc_stream_if.sink         tri_in,
  tcc_stream_if.source       vtx_out
);

  logic [CfgW-1:0] near_plane_q, screen_dist_q;

  // hold the plane and projection distance; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_plane_q  <= NearPlaneReset;
      screen_dist_q <= ScreenDistReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR_PLANE:  near_plane_q  <= cfg_data_i;
        CFG_SCREEN_DIST: screen_dist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcc_stream_if #(.T(tcc_job_t)) front_job ();
  tcc_stream_if #(.T(tcc_job_t)) back_job ();

  // classify, drop back-facing and fully hidden triangles
  tcc_front u_front (
    .clk_i, .rst_ni,
    .near_plane_i (near_plane_q),
    .tri_in       (tri_in),
    .job_out      (front_job)
  );

  tcc_fifo #(.Depth(QDepth), .T(tcc_job_t)) u_queue (
    .clk_i, .rst_ni,
    .push (front_job),
    .pop  (back_job)
  );

  // clip against the near plane, project, emit in walk order
  tcc_back u_back (
    .clk_i, .rst_ni,
    .near_plane_i  (near_plane_q),
    .screen_dist_i (screen_dist_q),
    .job_in        (back_job),
    .vtx_out       (vtx_out)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for triangle_cull_clip_project: directed table, then random
// triangles checked against an in-bench predictor. Needs tcc_pkg, tcc_stream_if and the RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  localparam int         ONE       = 65536;        // 1.0 in Q16.16
  localparam int         S32_MAX   = 2147483647;
  localparam int         S32_MIN   = -2147483648;
  localparam int         SETTLE    = 400;          // covers the slowest vertex in flight
  localparam int         MAX_CYC   = 3000000;
  localparam int         LONG_HOLD = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  tcc_stream_if #(.T(tcc_tri_t)) tri_if ();
  tcc_stream_if #(.T(tcc_vtx_t)) vtx_if ();

  triangle_cull_clip_project i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tri_in     (tri_if),
    .vtx_out    (vtx_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the configuration registers.
  longint   near_z;
  longint   dist_d;
  tcc_vtx_t vertex_q[$];
  int       n_errors;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_cycles;
  int       cycle_cnt;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  typedef struct {
    tcc_tri_t tri_v;
    int       n_exp;   // expected vertex count, -1 where the predictor alone decides
  } row_t;

  // Exact v0 . (v1 x v2); positive means the triangle faces away.
  function automatic logic signed [127:0] triple_product(tcc_tri_t t);
    logic signed [127:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
    x0 = t.v0_x; y0 = t.v0_y; z0 = t.v0_z;
    x1 = t.v1_x; y1 = t.v1_y; z1 = t.v1_z;
    x2 = t.v2_x; y2 = t.v2_y; z2 = t.v2_z;
    return x0 * (y1 * z2 - z1 * y2) + y0 * (z1 * x2 - x1 * z2) + z0 * (x1 * y2 - y1 * x2);
  endfunction

  function automatic longint clamp32(longint v);
    return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
  endfunction

  function automatic longint lerp_coord(longint c1, longint c2, longint unsigned s);
    longint          d;
    longint unsigned ad;
    longint          off;
    d   = c2 - c1;
    ad  = d < 0 ? -d : d;
    off = longint'((ad * s + (64'd1 << 29)) >> 30);
    return clamp32(d < 0 ? c1 - off : c1 + off);
  endfunction

  // Crossing point of edge p1 -> p2 with the near plane.
  function automatic point_t near_crossing(point_t p1, point_t p2);
    longint unsigned adz, and_, s;
    point_t r;
    adz  = (p2.z - p1.z) < 0 ? p1.z - p2.z : p2.z - p1.z;
    and_ = (near_z - p1.z) < 0 ? p1.z - near_z : near_z - p1.z;
    s    = 0;
    if (adz != 0) s = (and_ << 30) / adz;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    r.x = lerp_coord(p1.x, p2.x, s);
    r.y = lerp_coord(p1.y, p2.y, s);
    r.z = near_z;
    return r;
  endfunction

  function automatic longint project_coord(longint c, longint z);
    if (z == 0) return c > 0 ? S32_MAX : (c < 0 ? S32_MIN : 0);
    return clamp32((c * dist_d) / z);
  endfunction

  // Work out the projected polygon of one triangle and queue its vertices.
  function automatic int predict_polygon(tcc_tri_t t);
    point_t   v[3];
    point_t   poly[4];
    logic     front, clipped;
    int       n, nx;
    tcc_vtx_t o;
    v[0] = '{t.v0_x, t.v0_y, t.v0_z};
    v[1] = '{t.v1_x, t.v1_y, t.v1_z};
    v[2] = '{t.v2_x, t.v2_y, t.v2_z};
    front = 1'b0;
    clipped = 1'b0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      if (v[i].z > near_z) front = 1'b1;
      if (v[i].z < near_z) clipped = 1'b1;
    end
    if (triple_product(t) > 0 || !front) return 0;
    for (int i = 0; i < 3; i++) begin
      nx = (i == 2) ? 0 : i + 1;
      if (v[i].z < near_z) begin
        if (v[nx].z >= near_z) poly[n++] = near_crossing(v[i], v[nx]);
      end else begin
        poly[n++] = v[i];
        if (v[nx].z < near_z) poly[n++] = near_crossing(v[i], v[nx]);
      end
    end
    for (int i = 0; i < n; i++) begin
      o.screen_x    = 32'(project_coord(poly[i].x, poly[i].z));
      o.screen_y    = 32'(project_coord(poly[i].y, poly[i].z));
      o.depth       = 32'(poly[i].z);
      o.was_clipped = clipped;
      o.last_vertex = (i == n - 1);
      vertex_q.push_back(o);
    end
    return n;
  endfunction

  function automatic tcc_tri_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
    tcc_tri_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return t;
  endfunction

  // Random triangle: mostly small coordinates straddling the plane, facing the eye.
  function automatic tcc_tri_t rand_tri();
    tcc_tri_t t;
    int       r;
    longint   z;
    logic signed [CoordW-1:0] tmp;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      return t;
    end
    t = '0;
    t.v0_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    t.v0_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    t.v1_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    t.v1_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    t.v2_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    t.v2_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0:       z = near_z;
        1:       z = near_z + $urandom_range(0, 1 << 24);
        2:       z = longint'($signed($urandom));
        default: z = near_z + $urandom_range(0, 1 << 19) - (1 << 18);
      endcase
      z = clamp32(z);
      if (i == 0) t.v0_z = 32'(z);
      else if (i == 1) t.v1_z = 32'(z);
      else t.v2_z = 32'(z);
    end
    if (t.v0_z <= near_z && t.v1_z <= near_z && t.v2_z <= near_z)
      t.v0_z = 32'(clamp32(near_z + $urandom_range(1, 1 << 18)));
    // Flip the winding of triangles that face away, bar a few kept as noise.
    if (triple_product(t) > 0 && r < 90) begin
      tmp = t.v1_x; t.v1_x = t.v2_x; t.v2_x = tmp;
      tmp = t.v1_y; t.v1_y = t.v2_y; t.v2_y = tmp;
      tmp = t.v1_z; t.v1_z = t.v2_z; t.v2_z = tmp;
    end
    return t;
  endfunction

  // Offer one triangle, hold until accepted, then predict its vertices.
  task automatic send_tri(tcc_tri_t t, output int n);
    tri_if.valid <= 1'b1;
    tri_if.data  <= t;
    do @(posedge clk_i); while (!tri_if.ready);
    n = predict_polygon(t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      tri_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Write one register, with the write enable low again before the next write.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_NEAR_PLANE) near_z = longint'(val);
    else dist_d = longint'(val);
    @(posedge clk_i);
  endtask

  // Wait for every queued vertex, then let culled work in flight finish.
  task automatic drain();
    tri_if.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_random(int n_items, int pause_at);
    int n;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) begin
        // Hold off the sender until the output side has caught up.
        tri_if.valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      send_tri(rand_tri(), n);
    end
  endtask

  // Output side: random back-pressure and the field-by-field check.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_if.ready <= 1'b0;
    end else begin
      if (vtx_if.valid && vtx_if.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex with nothing expected: %p", vtx_if.data);
          n_errors++;
        end else begin
          tcc_vtx_t e;
          e = vertex_q.pop_front();
          if (vtx_if.data.screen_x !== e.screen_x) begin
            $error("screen_x exp %0d got %0d", e.screen_x, vtx_if.data.screen_x);
            n_errors++;
          end
          if (vtx_if.data.screen_y !== e.screen_y) begin
            $error("screen_y exp %0d got %0d", e.screen_y, vtx_if.data.screen_y);
            n_errors++;
          end
          if (vtx_if.data.depth !== e.depth) begin
            $error("depth exp %0d got %0d", e.depth, vtx_if.data.depth);
            n_errors++;
          end
          if (vtx_if.data.was_clipped !== e.was_clipped) begin
            $error("was_clipped exp %0b got %0b", e.was_clipped, vtx_if.data.was_clipped);
            n_errors++;
          end
          if (vtx_if.data.last_vertex !== e.last_vertex) begin
            $error("last_vertex exp %0b got %0b", e.last_vertex, vtx_if.data.last_vertex);
            n_errors++;
          end
        end
      end
      // Long hold-off counts down here; otherwise stall at random at recv_stall_pct.
      if (hold_cycles > 0) begin
        vtx_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        vtx_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int   n;
    n_errors       = 0;
    cycle_cnt      = 0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    near_z         = longint'(NearPlaneReset);
    dist_d         = longint'(ScreenDistReset);
    tri_if.valid   = 1'b0;
    tri_if.data    = '0;

    // Directed rows: winding, behind, on the plane, one or two in front, extremes.
    rows.push_back('{mk_tri(0, 0, ONE, 0, ONE, ONE, ONE, 0, ONE), 3});
    rows.push_back('{mk_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE), 0});
    rows.push_back('{mk_tri(0, 0, -ONE, 0, ONE, -ONE, ONE, 0, -ONE), 0});
    rows.push_back('{mk_tri(0, 0, ONE, 0, ONE, -ONE, ONE, 0, -ONE), -1});
    rows.push_back('{mk_tri(0, 0, ONE, 0, ONE, ONE, ONE, 0, -ONE), -1});
    rows.push_back('{mk_tri(0, 0, 19661, 0, ONE, 19661, ONE, 0, 19661), 0});
    rows.push_back('{mk_tri(0, 0, 19661, 0, ONE, 19661, ONE, 0, ONE), -1});
    rows.push_back('{mk_tri(0, 0, ONE, 0, 0, ONE, 0, 0, ONE), 3});
    rows.push_back('{mk_tri(S32_MAX, S32_MIN, 1, S32_MIN, S32_MAX, 1, 0, 0, 1), -1});
    rows.push_back('{mk_tri(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                            S32_MIN, S32_MIN, S32_MIN), 0});
    rows.push_back('{mk_tri(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX, S32_MAX), 3});
    rows.push_back('{mk_tri(S32_MIN, S32_MAX, ONE, S32_MAX, S32_MIN, S32_MAX, 0, 0, -ONE),
                     -1});
    rows.push_back('{mk_tri(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN,
                            0, 0, ONE), -1});
    rows.push_back('{mk_tri(-ONE, ONE, S32_MAX, ONE, -ONE, S32_MIN, 5, -5, 20000), -1});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, no idling.
    foreach (rows[i]) begin
      send_tri(rows[i].tri_v, n);
      if (rows[i].n_exp >= 0 && n != rows[i].n_exp) begin
        $error("vertex count of row %0d exp %0d got %0d", i, rows[i].n_exp, n);
        n_errors++;
      end
    end
    drain();

    // Smallest nonzero register values, idle sender.
    write_reg(CFG_NEAR_PLANE, 31'd1);
    write_reg(CFG_SCREEN_DIST, 31'd1);
    send_idle_pct = 69;
    run_random(60, -1);
    drain();

    // Highest distance, stalling receiver, one long hold-off to fill the block.
    write_reg(CFG_NEAR_PLANE, 31'(ONE));
    write_reg(CFG_SCREEN_DIST, 31'h7FFFFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    hold_cycles    = LONG_HOLD;
    run_random(60, -1);
    drain();

    // Farthest plane culls everything.
    write_reg(CFG_NEAR_PLANE, 31'h7FFFFFFF);
    run_random(15, -1);
    drain();

    // Back to defaults, both sides idle, one pause until all is drained.
    write_reg(CFG_NEAR_PLANE, NearPlaneReset);
    write_reg(CFG_SCREEN_DIST, ScreenDistReset);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(70, 35);
    drain();

    // Mid settings, no idling.
    write_reg(CFG_NEAR_PLANE, 31'd3277);
    write_reg(CFG_SCREEN_DIST, 31'(ONE * 2));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(60, -1);
    drain();

    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
